FILE: hdl/shell_sort_records_by_key_assert.svh
// assertion macros for the shell sort block
// used by ssrk_datapath under hdl, no other dependencies
`ifndef SHELL_SORT_RECORDS_BY_KEY_ASSERT_SVH
`define SHELL_SORT_RECORDS_BY_KEY_ASSERT_SVH

`ifndef SYNTHESIS
`define SSRK_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");
`define SSRK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define SSRK_ASSERT(lbl, clk, rstn, prop)
`define SSRK_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: hdl/ssrk_pkg.sv
// shared types for the shell sort block: words, stored record, command and status
// no dependencies
package ssrk_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned TagW = 16;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [TagW-1:0]        payload_tag;
    logic                   last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [KeyW-1:0] sorted_key;
    logic [TagW-1:0]        sorted_tag;
    logic                   last_out;
    logic                   overflowed;
  } out_word_t;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [TagW-1:0]        tag;
  } rec_t;

  typedef struct packed {
    logic load;
    logic init;
    logic rd_i;
    logic hold_ld;
    logic rd_jg;
    logic mv;
    logic put;
    logic next_i;
    logic next_gap;
    logic out_ld;
  } ssrk_cmd_t;

  typedef struct packed {
    logic in_last;
    logic gap_zero;
    logic j_ge_gap;
    logic greater;
    logic i_more;
    logic out_free;
    logic k_last;
  } ssrk_stat_t;

endpackage

FILE: hdl/ssrk_if.sv
// valid/ready channel interfaces for input and result words
// depends on ssrk_pkg
interface ssrk_in_if import ssrk_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssrk_out_if import ssrk_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ssrk_ctrl.sv
// sequencer for load, shell sort passes and readout
// depends on ssrk_pkg, drives ssrk_datapath through command and status structs
module ssrk_ctrl import ssrk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ssrk_stat_t stat_i,
  output ssrk_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    S_LOAD  = 10'b00_0000_0001,
    S_INIT  = 10'b00_0000_0010,
    S_GAP   = 10'b00_0000_0100,
    S_IRD   = 10'b00_0000_1000,
    S_IWAIT = 10'b00_0001_0000,
    S_JCHK  = 10'b00_0010_0000,
    S_JWAIT = 10'b00_0100_0000,
    S_NEXT  = 10'b00_1000_0000,
    S_ORD   = 10'b01_0000_0000,
    S_OLD   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.load = 1'b1;
        if (stat_i.in_last) state_d = S_INIT;
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_GAP;
      end
      S_GAP: begin
        state_d = stat_i.gap_zero ? S_ORD : S_IRD;
      end
      S_IRD: begin
        cmd_o.rd_i = 1'b1;
        state_d    = S_IWAIT;
      end
      S_IWAIT: begin
        cmd_o.hold_ld = 1'b1;
        state_d       = S_JCHK;
      end
      S_JCHK: begin
        if (stat_i.j_ge_gap) begin
          cmd_o.rd_jg = 1'b1;
          state_d     = S_JWAIT;
        end else begin
          cmd_o.put = 1'b1;
          state_d   = S_NEXT;
        end
      end
      S_JWAIT: begin
        if (stat_i.greater) begin
          cmd_o.mv = 1'b1;
          state_d  = S_JCHK;
        end else begin
          cmd_o.put = 1'b1;
          state_d   = S_NEXT;
        end
      end
      S_NEXT: begin
        if (stat_i.i_more) begin
          cmd_o.next_i = 1'b1;
          state_d      = S_IRD;
        end else begin
          cmd_o.next_gap = 1'b1;
          state_d        = S_GAP;
        end
      end
      S_ORD: begin
        state_d = S_OLD;
      end
      S_OLD: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = stat_i.k_last ? S_LOAD : S_ORD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/ssrk_datapath.sv
// record store, sort indexes, compare and output register
// depends on ssrk_pkg, ssrk_if and the assertion macro header
`include "shell_sort_records_by_key_assert.svh"

module ssrk_datapath import ssrk_pkg::*; #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ssrk_in_if.sink       in_i,
  ssrk_out_if.source    out_o,
  input  ssrk_cmd_t     cmd_i,
  output ssrk_stat_t    stat_o
);

  localparam int unsigned IdxW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);

  rec_t mem [MAX_RECORDS];
  rec_t rdata_q;
  rec_t hold_q;

  logic [CntW-1:0] count_q, gap_q, i_q, j_q, k_q;
  logic            ovf_q;
  logic            out_valid_q;
  out_word_t       out_q;

  logic            in_fire, out_fire, full;
  logic [CntW-1:0] jg, raddr_w;
  logic            wr_en;
  logic [IdxW-1:0] waddr;
  rec_t            wdata;

  assign in_i.ready  = cmd_i.load;
  assign in_fire     = in_i.valid && cmd_i.load;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign out_fire    = out_valid_q && out_o.ready;
  assign full        = (count_q == CntW'(MAX_RECORDS));
  assign jg          = j_q - gap_q;

  assign stat_o.in_last  = in_fire && in_i.data.last_in;
  assign stat_o.gap_zero = (gap_q == '0);
  assign stat_o.j_ge_gap = (j_q >= gap_q);
  assign stat_o.greater  = (rdata_q.key > hold_q.key);
  assign stat_o.i_more   = ((i_q + CntW'(1)) < count_q);
  assign stat_o.out_free = !out_valid_q || out_o.ready;
  assign stat_o.k_last   = ((k_q + CntW'(1)) == count_q);

  always_comb begin
    priority if (cmd_i.rd_jg) raddr_w = jg;
    else if (cmd_i.rd_i)      raddr_w = i_q;
    else                      raddr_w = k_q;
  end

  always_comb begin
    wr_en = 1'b0;
    waddr = j_q[IdxW-1:0];
    wdata = hold_q;
    priority if (cmd_i.mv) begin
      wr_en = 1'b1;
      wdata = rdata_q;
    end else if (cmd_i.put) begin
      wr_en = 1'b1;
    end else if (in_fire && !full) begin
      wr_en = 1'b1;
      waddr = count_q[IdxW-1:0];
      wdata = '{key: in_i.data.key, tag: in_i.data.payload_tag};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr] <= wdata;
    rdata_q <= mem[raddr_w[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_ld) hold_q <= rdata_q;
    if (cmd_i.out_ld) begin
      out_q.sorted_key <= rdata_q.key;
      out_q.sorted_tag <= rdata_q.tag;
      out_q.last_out   <= stat_o.k_last;
      out_q.overflowed <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      gap_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        if (full) ovf_q <= 1'b1;
        else      count_q <= count_q + CntW'(1);
      end
      if (cmd_i.init) begin
        gap_q <= count_q >> 1;
        i_q   <= count_q >> 1;
        k_q   <= '0;
      end
      if (cmd_i.hold_ld) j_q <= i_q;
      if (cmd_i.mv)      j_q <= jg;
      if (cmd_i.next_i)  i_q <= i_q + CntW'(1);
      if (cmd_i.next_gap) begin
        gap_q <= gap_q >> 1;
        i_q   <= gap_q >> 1;
      end
      if (cmd_i.out_ld) begin
        k_q <= k_q + CntW'(1);
        if (stat_o.k_last) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end
      end
      if (cmd_i.out_ld)  out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;
    end
  end

  `SSRK_ASSERT_ALWAYS(a_count_bound, clk_i, count_q <= CntW'(MAX_RECORDS))
  `SSRK_ASSERT(a_sort_wr_in_set, clk_i, rst_ni, (cmd_i.mv || cmd_i.put) |-> (j_q < count_q))
  `SSRK_ASSERT(a_set_cleared, clk_i, rst_ni, (cmd_i.out_ld && stat_o.k_last) |=> (count_q == '0))
  `SSRK_ASSERT(a_out_ld_free, clk_i, rst_ni, cmd_i.out_ld |-> (!out_valid_q || out_o.ready))

endmodule

FILE: hdl/shell_sort_records_by_key.sv
// load: one record per cycle while loading; a closing record starts the sort
// sort: an init state, a gap state per pass, and per index i a read, a hold load,
//   then a compare and move per record shifted, ending with a put of the held record
// readout: each record is read, then loaded when the output register frees; next set loads
//   once the final result sits in the output register
// reset: asynchronous, clears count, overflow flag, indexes and output valid
module shell_sort_records_by_key import ssrk_pkg::*; #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssrk_in_if.sink    in_i,
  ssrk_out_if.source out_o
);

  ssrk_cmd_t  cmd;
  ssrk_stat_t stat;

  ssrk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  ssrk_datapath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule
